@@ hdl/sexpr_token_lexer_top_assert.svh @@
// Assertion macros for the lexer checker.
`ifndef SEXPR_TOKEN_LEXER_TOP_ASSERT_SVH
`define SEXPR_TOKEN_LEXER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SXL_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("sxl: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SXL_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sxl: next-cycle check failed");

`endif

@@ hdl/sxl_pkg.sv @@
// Shared types and constants for the s-expression token lexer.
package sxl_pkg;

    localparam int KIND_W  = 3;
    localparam int ERROR_W = 2;
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_LPAREN     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RPAREN     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INTEGER    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SYMBOL     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END        = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNEXPECTED = 3'd5;

    localparam logic [ERROR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERROR_W-1:0] ERR_RANGE   = 2'd1;
    localparam logic [ERROR_W-1:0] ERR_INVALID = 2'd2;

    typedef struct packed {
        logic push0;
        logic push1;
    } push_t;

endpackage

@@ hdl/sxl_outq.sv @@
// Four-entry result queue that takes up to two words per cycle and gives one per cycle while out_ready is high.
module sxl_outq #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sxl_pkg::push_t    push,
    input  logic [DATA_W-1:0] din0,
    input  logic [DATA_W-1:0] din1,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] dout
);
    import sxl_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        n_push;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign ready     = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop       = out_valid && out_ready;
    assign n_push    = {1'b0, push.push0} + {1'b0, push.push1};
    assign dout      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[wr_ptr_reg] <= din0;
        end
        if (push.push1)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/sxl_scan.sv @@
// Scanner state, character classes, integer accumulation and token formation.
module sxl_scan #(
    parameter int POSITION_BITS = 32,
    localparam int RAW_W = sxl_pkg::ERROR_W + sxl_pkg::VALUE_W + 6 * POSITION_BITS
                           + sxl_pkg::CHAR_W,
    localparam int TDATA_W = ((RAW_W + 7) / 8) * 8,
    localparam int ENTRY_W = TDATA_W + sxl_pkg::KIND_W + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic                       action,
    input  logic [sxl_pkg::CHAR_W-1:0] byte_req,
    output sxl_pkg::push_t             push,
    output logic [ENTRY_W-1:0]         entry0,
    output logic [ENTRY_W-1:0]         entry1
);
    import sxl_pkg::*;

    localparam int P = POSITION_BITS;

    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI       = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LESS       = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQUAL      = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_GREATER    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_QUEST      = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;

    // Largest magnitudes that can take one more digit (0 to 8, or 9) without passing 2^63.
    localparam logic [VALUE_W-1:0] ACC_LIMIT    = 64'd922337203685477580;
    localparam logic [VALUE_W-1:0] ACC_LIMIT_9  = 64'd922337203685477579;
    localparam logic [VALUE_W-1:0] NEG_LIMIT    = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] POS_LIMIT    = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'b001,
        MODE_COMMENT = 3'b010,
        MODE_WORD    = 3'b100
    } mode_t;

    typedef struct packed {
        logic minus;
        logic digit_first;
        logic saw_digit;
        logic not_int;
    } wflags_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  bad_char;
        logic [P-1:0]       end_col;
        logic [P-1:0]       end_line;
        logic [P-1:0]       start_col;
        logic [P-1:0]       start_line;
        logic [P-1:0]       end_offset;
        logic [P-1:0]       start_offset;
        logic [VALUE_W-1:0] value;
        logic [ERROR_W-1:0] error;
    } tok_t;

    mode_t              mode_reg, mode_next;
    logic [P-1:0]       offset_reg, offset_next;
    logic [P-1:0]       line_reg, line_next;
    logic [P-1:0]       col_reg, col_next;
    logic [P-1:0]       wstart_off_reg, wstart_off_next;
    logic [P-1:0]       wstart_line_reg, wstart_line_next;
    logic [P-1:0]       wstart_col_reg, wstart_col_next;
    wflags_t            flags_reg, flags_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               ovf_reg, ovf_next;

    logic               is_digit, is_alpha, is_punct, is_sym, is_ws, is_lf;
    logic [3:0]         digit;
    logic [VALUE_W-1:0] acc_limit, acc_mag;
    logic               acc_ovf;
    logic [P-1:0]       off_inc, line_inc, col_inc, adv_line, adv_col;
    logic               w_int, w_range_bad;
    logic [KIND_W-1:0]  w_kind, b_kind;
    tok_t               w_tok, b_tok;
    logic               flush, emit;

    assign is_lf    = (byte_req == CH_LF);
    assign is_ws    = (byte_req == CH_SPACE) || (byte_req == CH_TAB) ||
                      (byte_req == CH_CR) || is_lf;
    assign is_digit = (byte_req >= CH_ZERO) && (byte_req <= CH_NINE);
    assign is_alpha = ((byte_req >= CH_UPPER_A) && (byte_req <= CH_UPPER_Z)) ||
                      ((byte_req >= CH_LOWER_A) && (byte_req <= CH_LOWER_Z));
    assign is_punct = (byte_req == CH_UNDERSCORE) || (byte_req == CH_MINUS) ||
                      (byte_req == CH_QUEST) || (byte_req == CH_BANG) ||
                      (byte_req == CH_LESS) || (byte_req == CH_GREATER) ||
                      (byte_req == CH_EQUAL) || (byte_req == CH_PLUS) ||
                      (byte_req == CH_STAR) || (byte_req == CH_SLASH) ||
                      (byte_req == CH_DOT);
    assign is_sym   = is_digit || is_alpha || is_punct;
    assign digit    = 4'(byte_req - CH_ZERO);

    // Decimal accumulation; once overflowed the magnitude is frozen.
    assign acc_limit = (digit == 4'd9) ? ACC_LIMIT_9 : ACC_LIMIT;
    assign acc_ovf   = ovf_reg || (mag_reg > acc_limit);
    assign acc_mag   = (mag_reg << 3) + (mag_reg << 1) + VALUE_W'(digit);

    // Position counters saturate at all ones.
    assign off_inc  = (offset_reg == '1) ? offset_reg : offset_reg + P'(1);
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + P'(1);
    assign col_inc  = (col_reg == '1) ? col_reg : col_reg + P'(1);
    assign adv_line = is_lf ? line_inc : line_reg;
    assign adv_col  = is_lf ? P'(1) : col_inc;

    assign w_int       = !flags_reg.not_int && flags_reg.saw_digit;
    assign w_range_bad = ovf_reg || (flags_reg.minus ? (mag_reg > NEG_LIMIT)
                                                     : (mag_reg > POS_LIMIT));
    assign w_kind      = w_int ? KIND_INTEGER : KIND_SYMBOL;

    always_comb
    begin
        w_tok              = '0;
        w_tok.start_offset = wstart_off_reg;
        w_tok.start_line   = wstart_line_reg;
        w_tok.start_col    = wstart_col_reg;
        w_tok.end_offset   = offset_reg;
        w_tok.end_line     = line_reg;
        w_tok.end_col      = col_reg;
        if (w_int)
        begin
            w_tok.error = w_range_bad ? ERR_RANGE : ERR_NONE;
            if (!w_range_bad)
            begin
                w_tok.value = flags_reg.minus ? -mag_reg : mag_reg;
            end
        end
        else
        begin
            w_tok.error = flags_reg.digit_first ? ERR_INVALID : ERR_NONE;
        end
    end

    always_comb
    begin
        b_tok              = '0;
        b_tok.start_offset = offset_reg;
        b_tok.start_line   = line_reg;
        b_tok.start_col    = col_reg;
        if (action == ACTION_END)
        begin
            b_tok.end_offset = offset_reg;
            b_tok.end_line   = line_reg;
            b_tok.end_col    = col_reg;
        end
        else
        begin
            b_tok.end_offset = off_inc;
            b_tok.end_line   = adv_line;
            b_tok.end_col    = adv_col;
        end
        b_tok.bad_char = (b_kind == KIND_UNEXPECTED) ? byte_req : '0;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        offset_next      = offset_reg;
        line_next        = line_reg;
        col_next         = col_reg;
        wstart_off_next  = wstart_off_reg;
        wstart_line_next = wstart_line_reg;
        wstart_col_next  = wstart_col_reg;
        flags_next       = flags_reg;
        mag_next         = mag_reg;
        ovf_next         = ovf_reg;
        flush            = 1'b0;
        emit             = 1'b0;
        b_kind           = KIND_END;
        if (take)
        begin
            if (action == ACTION_END)
            begin
                // A pending word goes out ahead of End, then the scan starts over.
                flush            = (mode_reg == MODE_WORD);
                emit             = 1'b1;
                mode_next        = MODE_NORMAL;
                offset_next      = '0;
                line_next        = P'(1);
                col_next         = P'(1);
                wstart_off_next  = '0;
                wstart_line_next = P'(1);
                wstart_col_next  = P'(1);
                flags_next       = '0;
                mag_next         = '0;
                ovf_next         = 1'b0;
            end
            else
            begin
                offset_next = off_inc;
                line_next   = adv_line;
                col_next    = adv_col;
                if (mode_reg == MODE_COMMENT)
                begin
                    if (is_lf)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                else if ((mode_reg == MODE_WORD) && is_sym)
                begin
                    if (is_digit)
                    begin
                        flags_next.saw_digit = 1'b1;
                        ovf_next             = acc_ovf;
                        mag_next             = acc_ovf ? mag_reg : acc_mag;
                    end
                    else
                    begin
                        flags_next.not_int = 1'b1;
                    end
                end
                else
                begin
                    flush     = (mode_reg == MODE_WORD);
                    mode_next = MODE_NORMAL;
                    if (is_ws)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (byte_req == CH_SEMI)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else if (byte_req == CH_LPAREN)
                    begin
                        emit   = 1'b1;
                        b_kind = KIND_LPAREN;
                    end
                    else if (byte_req == CH_RPAREN)
                    begin
                        emit   = 1'b1;
                        b_kind = KIND_RPAREN;
                    end
                    else if (is_sym)
                    begin
                        mode_next              = MODE_WORD;
                        wstart_off_next        = offset_reg;
                        wstart_line_next       = line_reg;
                        wstart_col_next        = col_reg;
                        flags_next.minus       = (byte_req == CH_MINUS);
                        flags_next.digit_first = is_digit;
                        flags_next.saw_digit   = is_digit;
                        flags_next.not_int     = !is_digit && (byte_req != CH_MINUS);
                        mag_next               = is_digit ? VALUE_W'(digit) : '0;
                        ovf_next               = 1'b0;
                    end
                    else
                    begin
                        emit   = 1'b1;
                        b_kind = KIND_UNEXPECTED;
                    end
                end
            end
        end
    end

    assign push.push0 = flush || emit;
    assign push.push1 = flush && emit;
    assign entry1     = {b_kind, 1'b1, TDATA_W'(b_tok)};
    assign entry0     = flush ? {w_kind, !emit, TDATA_W'(w_tok)} : entry1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NORMAL;
            offset_reg      <= '0;
            line_reg        <= P'(1);
            col_reg         <= P'(1);
            wstart_off_reg  <= '0;
            wstart_line_reg <= P'(1);
            wstart_col_reg  <= P'(1);
            flags_reg       <= '0;
            mag_reg         <= '0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            offset_reg      <= offset_next;
            line_reg        <= line_next;
            col_reg         <= col_next;
            wstart_off_reg  <= wstart_off_next;
            wstart_line_reg <= wstart_line_next;
            wstart_col_reg  <= wstart_col_next;
            flags_reg       <= flags_next;
            mag_reg         <= mag_next;
            ovf_reg         <= ovf_next;
        end
    end

endmodule

@@ hdl/sexpr_token_lexer_top.sv @@
// Top level of the s-expression token lexer.
//
// Channel  Dir  tdata                         tuser        tlast
// s_*      in   byte_req                      action       -
// m_*      out  error, value, spans, bad_char kind         last
//
// One byte word is taken per cycle while s_tready is high; the scanner state updates
// in that cycle and its tokens enter a four-entry result queue, visible in the next cycle.
// A byte gives zero, one or two tokens; the queue drains one token per cycle while m_tready is high.
// s_tready is low while the queue has fewer than two free entries.
// Reset (rst_n low, asynchronous) empties the queue and restarts the scan at
// offset 0, line 1, column 1. m_tready low only stalls the queue.
module sexpr_token_lexer_top #(
    parameter int POSITION_BITS = 32,
    localparam int RAW_W = sxl_pkg::ERROR_W + sxl_pkg::VALUE_W + 6 * POSITION_BITS
                           + sxl_pkg::CHAR_W,
    localparam int TDATA_W = ((RAW_W + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sxl_pkg::CHAR_W-1:0] s_tdata,  // byte_req
    input  logic                       s_tuser,  // action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // error, value, start_offset, end_offset, start_line, start_col,
    // end_line, end_col, bad_char, zero fill
    output logic [TDATA_W-1:0]         m_tdata,
    output logic [sxl_pkg::KIND_W-1:0] m_tuser,  // kind
    output logic                       m_tlast
);
    import sxl_pkg::*;

    localparam int ENTRY_W = TDATA_W + KIND_W + 1;

    push_t              push;
    logic [ENTRY_W-1:0] entry0, entry1, head;
    logic               take;

    assign take = s_tvalid && s_tready;

    sxl_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .action   (s_tuser),
        .byte_req (s_tdata),
        .push     (push),
        .entry0   (entry0),
        .entry1   (entry1)
    );

    sxl_outq #(
        .DATA_W(ENTRY_W)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din0      (entry0),
        .din1      (entry1),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (head)
    );

    assign m_tuser = head[ENTRY_W-1 -: KIND_W];
    assign m_tlast = head[TDATA_W];
    assign m_tdata = head[TDATA_W-1:0];

endmodule

@@ hdl/sxl_chk.sv @@
// Port-level checker for the lexer top level and its bind.
`include "sexpr_token_lexer_top_assert.svh"

module sxl_chk #(
    parameter int POSITION_BITS = 32,
    localparam int RAW_W = sxl_pkg::ERROR_W + sxl_pkg::VALUE_W + 6 * POSITION_BITS
                           + sxl_pkg::CHAR_W,
    localparam int TDATA_W = ((RAW_W + 7) / 8) * 8
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [TDATA_W-1:0]         m_tdata,
    input logic [sxl_pkg::KIND_W-1:0] m_tuser,
    input logic                       m_tlast
);
    import sxl_pkg::*;

    localparam int BAD_LSB = ERROR_W + VALUE_W + 6 * POSITION_BITS;

    logic [ERROR_W-1:0] err;
    logic [CHAR_W-1:0]  bad;

    assign err = m_tdata[ERROR_W-1:0];
    assign bad = m_tdata[BAD_LSB +: CHAR_W];

    `SXL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `SXL_ASSERT_NOW(a_kind_range, m_tvalid, m_tuser <= KIND_UNEXPECTED)
    `SXL_ASSERT_NOW(a_bad_only_unexp, m_tvalid && (m_tuser != KIND_UNEXPECTED), bad == '0)
    `SXL_ASSERT_NOW(a_end_is_last, m_tvalid && (m_tuser == KIND_END), m_tlast && (err == ERR_NONE))
    `SXL_ASSERT_NOW(a_err_on_word, m_tvalid && (err != ERR_NONE), (m_tuser == KIND_INTEGER) || (m_tuser == KIND_SYMBOL))

endmodule

bind sexpr_token_lexer_top sxl_chk #(
    .POSITION_BITS(POSITION_BITS)
) u_sxl_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ bench/sexpr_token_lexer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the s-expression token lexer: predicts tokens from accepted bytes and compares them.
module sexpr_token_lexer_checker #(
    parameter int POSITION_BITS = 32,
    parameter int TDATA_W       = 272
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [sxl_pkg::CHAR_W-1:0] s_tdata,  // byte_req
    input  logic                       s_tuser,  // action
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    // error, value, start_offset, end_offset, start_line, start_col,
    // end_line, end_col, bad_char, zero fill
    input  logic [TDATA_W-1:0]         m_tdata,
    input  logic [sxl_pkg::KIND_W-1:0] m_tuser,  // kind
    input  logic                       m_tlast,
    output int                         errors,
    output int                         pending
);
    import sxl_pkg::*;

    localparam int PB        = POSITION_BITS;
    localparam int RAW_W     = ERROR_W + VALUE_W + 6 * PB + CHAR_W;
    localparam int VALUE_LSB = ERROR_W;
    localparam int SO_LSB    = VALUE_LSB + VALUE_W;
    localparam int EO_LSB    = SO_LSB + PB;
    localparam int SL_LSB    = EO_LSB + PB;
    localparam int SC_LSB    = SL_LSB + PB;
    localparam int EL_LSB    = SC_LSB + PB;
    localparam int EC_LSB    = EL_LSB + PB;
    localparam int BAD_LSB   = EC_LSB + PB;

    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    localparam logic [3:0] FLAG_MINUS       = 4'd1;
    localparam logic [3:0] FLAG_DIGIT_FIRST = 4'd2;
    localparam logic [3:0] FLAG_SAW_DIGIT   = 4'd4;
    localparam logic [3:0] FLAG_NOT_INT     = 4'd8;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [2:0] {
        SCAN_NORMAL  = 3'b001,
        SCAN_COMMENT = 3'b010,
        SCAN_WORD    = 3'b100
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ERROR_W-1:0] err;
        logic [VALUE_W-1:0] value;
        logic [PB-1:0]      so;
        logic [PB-1:0]      eo;
        logic [PB-1:0]      sl;
        logic [PB-1:0]      sc;
        logic [PB-1:0]      el;
        logic [PB-1:0]      ec;
        logic [CHAR_W-1:0]  bad;
        logic               last;
    } token_t;

    scan_mode_t    mode;
    logic [PB-1:0] offset_cnt, line_cnt, col_cnt;
    logic [PB-1:0] word_offset, word_line, word_col;
    logic [3:0]    word_flags;
    logic [63:0]   magnitude;
    logic          overflowed;
    int            step_tokens;
    token_t        expected_tokens[$];

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v == {PB{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_word_char(input logic [7:0] b);
        if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || is_digit(b))
            return 1'b1;
        case (b)
            "_", "-", "?", "!", "<", ">", "=", "+", "*", "/", ".": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic string token_text(input token_t t);
        return $sformatf({"kind %0d err %0d value %0d span %0d..%0d ",
                          "(%0d:%0d)-(%0d:%0d) bad %0h last %0d"},
                         t.kind, t.err, $signed(t.value), t.so, t.eo, t.sl, t.sc,
                         t.el, t.ec, t.bad, t.last);
    endfunction

    task automatic reset_scan();
        mode        = SCAN_NORMAL;
        offset_cnt  = '0;
        line_cnt    = PB'(1);
        col_cnt     = PB'(1);
        word_offset = '0;
        word_line   = PB'(1);
        word_col    = PB'(1);
        word_flags  = '0;
        magnitude   = '0;
        overflowed  = 1'b0;
    endtask

    task automatic advance_pos(input logic [7:0] b);
        if (b == CH_LF)
        begin
            line_cnt = sat_inc(line_cnt);
            col_cnt  = PB'(1);
        end
        else
        begin
            col_cnt = sat_inc(col_cnt);
        end
        offset_cnt = sat_inc(offset_cnt);
    endtask

    task automatic add_token(input logic [KIND_W-1:0] kind, input logic [ERROR_W-1:0] err,
                             input logic [63:0] val, input logic [PB-1:0] so,
                             input logic [PB-1:0] sl, input logic [PB-1:0] sc,
                             input logic [7:0] bad);
        token_t t;
        t.kind  = kind;
        t.err   = err;
        t.value = val;
        t.so    = so;
        t.eo    = offset_cnt;
        t.sl    = sl;
        t.sc    = sc;
        t.el    = line_cnt;
        t.ec    = col_cnt;
        t.bad   = bad;
        t.last  = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
        step_tokens++;
    endtask

    task automatic accumulate_digit(input logic [7:0] b);
        logic [7:0]  digit;
        logic [63:0] d;
        digit      = b - CH_ZERO;
        d          = {56'd0, digit};
        word_flags = word_flags | FLAG_SAW_DIGIT;
        if (!overflowed)
        begin
            if (magnitude > (NEG_LIMIT - d) / 64'd10)
                overflowed = 1'b1;
            else
                magnitude = magnitude * 64'd10 + d;
        end
    endtask

    task automatic flush_word();
        logic [KIND_W-1:0]  kind;
        logic [ERROR_W-1:0] err;
        logic [63:0]        val;
        kind = KIND_SYMBOL;
        err  = ERR_NONE;
        val  = '0;
        if ((word_flags & FLAG_NOT_INT) == '0 && (word_flags & FLAG_SAW_DIGIT) != '0)
        begin
            kind = KIND_INTEGER;
            if ((word_flags & FLAG_MINUS) != '0)
            begin
                if (overflowed || magnitude > NEG_LIMIT)
                    err = ERR_RANGE;
                else
                    val = 64'd0 - magnitude;
            end
            else
            begin
                if (overflowed || magnitude > NEG_LIMIT - 64'd1)
                    err = ERR_RANGE;
                else
                    val = magnitude;
            end
        end
        else if ((word_flags & FLAG_DIGIT_FIRST) != '0)
        begin
            err = ERR_INVALID;
        end
        add_token(kind, err, val, word_offset, word_line, word_col, '0);
        mode = SCAN_NORMAL;
    endtask

    task automatic lex_normal(input logic [7:0] b);
        logic [PB-1:0] so, sl, sc;
        so = offset_cnt;
        sl = line_cnt;
        sc = col_cnt;
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
        begin
            advance_pos(b);
        end
        else if (b == CH_SEMI)
        begin
            mode = SCAN_COMMENT;
            advance_pos(b);
        end
        else if (b == CH_LPAREN || b == CH_RPAREN)
        begin
            advance_pos(b);
            add_token(b == CH_LPAREN ? KIND_LPAREN : KIND_RPAREN, ERR_NONE, '0,
                      so, sl, sc, '0);
        end
        else if (is_word_char(b))
        begin
            word_offset = so;
            word_line   = sl;
            word_col    = sc;
            word_flags  = '0;
            magnitude   = '0;
            overflowed  = 1'b0;
            if (b == CH_MINUS)
            begin
                word_flags = FLAG_MINUS;
            end
            else if (is_digit(b))
            begin
                word_flags = FLAG_DIGIT_FIRST;
                accumulate_digit(b);
            end
            else
            begin
                word_flags = FLAG_NOT_INT;
            end
            advance_pos(b);
            mode = SCAN_WORD;
        end
        else
        begin
            advance_pos(b);
            add_token(KIND_UNEXPECTED, ERR_NONE, '0, so, sl, sc, b);
        end
    endtask

    task automatic lex_item(input logic action, input logic [7:0] b);
        step_tokens = 0;
        if (action == ACTION_END)
        begin
            if (mode == SCAN_WORD)
                flush_word();
            add_token(KIND_END, ERR_NONE, '0, offset_cnt, line_cnt, col_cnt, '0);
            reset_scan();
        end
        else if (mode == SCAN_COMMENT)
        begin
            if (b == CH_LF)
                mode = SCAN_NORMAL;
            advance_pos(b);
        end
        else if (mode == SCAN_WORD && is_word_char(b))
        begin
            if (is_digit(b))
                accumulate_digit(b);
            else
                word_flags = word_flags | FLAG_NOT_INT;
            advance_pos(b);
        end
        else
        begin
            if (mode == SCAN_WORD)
                flush_word();
            mode = SCAN_NORMAL;
            lex_normal(b);
        end
        if (step_tokens > 0)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    task automatic check_token();
        token_t seen;
        token_t want;
        seen.kind  = m_tuser;
        seen.err   = m_tdata[0 +: ERROR_W];
        seen.value = m_tdata[VALUE_LSB +: VALUE_W];
        seen.so    = m_tdata[SO_LSB +: PB];
        seen.eo    = m_tdata[EO_LSB +: PB];
        seen.sl    = m_tdata[SL_LSB +: PB];
        seen.sc    = m_tdata[SC_LSB +: PB];
        seen.el    = m_tdata[EL_LSB +: PB];
        seen.ec    = m_tdata[EC_LSB +: PB];
        seen.bad   = m_tdata[BAD_LSB +: CHAR_W];
        seen.last  = m_tlast;
        if (expected_tokens.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("token with none expected: %s", token_text(seen));
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (seen !== want || (m_tdata >> RAW_W) != '0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("token mismatch, expected: %s", token_text(want));
                    $display("                  actual: %s fill %0h",
                             token_text(seen), m_tdata >> RAW_W);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_scan();
            expected_tokens.delete();
            errors = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_token();
            if (s_tvalid && s_tready)
                lex_item(s_tuser, s_tdata);
        end
        pending <= expected_tokens.size();
    end

endmodule

@@ bench/tb_sexpr_token_lexer_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the s-expression token lexer: clock, reset, byte stimulus and verdict.
module tb_sexpr_token_lexer_top;
    import sxl_pkg::*;

    localparam int POS_W       = 32;
    localparam int RAW_W       = ERROR_W + VALUE_W + 6 * POS_W + CHAR_W;
    localparam int TDATA_W     = ((RAW_W + 7) / 8) * 8;
    localparam int ITEM_TARGET = 800;
    localparam int STALL_LIMIT = 3000;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]  m_tuser;
    logic               m_tlast;
    int                 errors;
    int                 pending;
    int                 items_sent;
    int                 quiet_cycles;
    bit                 idle_on;

    sexpr_token_lexer_top #(
        .POSITION_BITS(POS_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    sexpr_token_lexer_checker #(
        .POSITION_BITS(POS_W),
        .TDATA_W      (TDATA_W)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sexpr_token_lexer_top");
            $finish;
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
    end

    task automatic send_item(input logic action, input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(0, 10)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= action;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(ACTION_BYTE, text[i]);
    endtask

    task automatic send_from_set(input int count, input string charset);
        repeat (count) send_item(ACTION_BYTE, charset[$urandom_range(0, charset.len() - 1)]);
    endtask

    task automatic send_separator();
        case ($urandom_range(0, 5))
            0: send_item(ACTION_BYTE, CH_SPACE);
            1: send_item(ACTION_BYTE, CH_TAB);
            2: send_item(ACTION_BYTE, CH_CR);
            3: send_item(ACTION_BYTE, CH_LF);
            4: send_item(ACTION_BYTE, CH_LPAREN);
            default: send_item(ACTION_BYTE, CH_RPAREN);
        endcase
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic send_random_token();
        string digits;
        string symbols;
        string extremes[8];
        int    pick;
        digits   = "0123456789";
        symbols  = "abmzAQZ_-?!<>=+*/.0123456789";
        extremes = '{"9223372036854775807", "9223372036854775808",
                     "-9223372036854775808", "-9223372036854775809",
                     "99999999999999999999", "0000000000000000000000001",
                     "-0", "18446744073709551616"};
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            send_item(ACTION_BYTE, CH_LPAREN);
        end
        else if (pick < 20)
        begin
            send_item(ACTION_BYTE, CH_RPAREN);
        end
        else if (pick < 30)
        begin
            send_separator();
        end
        else if (pick < 36)
        begin
            send_item(ACTION_BYTE, CH_SEMI);
            repeat ($urandom_range(0, 6)) send_item(ACTION_BYTE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0)
                send_item(ACTION_END, 8'($urandom_range(0, 255)));
            else
                send_item(ACTION_BYTE, CH_LF);
        end
        else if (pick < 76)
        begin
            if (pick < 56)
            begin
                if ($urandom_range(0, 1) == 1)
                    send_item(ACTION_BYTE, CH_MINUS);
                send_from_set($urandom_range(0, 7) == 0 ? $urandom_range(1, 22)
                                                        : $urandom_range(1, 5), digits);
            end
            else if (pick < 68)
            begin
                send_from_set(1, "abzAZ_?!<>=+*/.-");
                send_from_set($urandom_range(0, 5), symbols);
            end
            else
            begin
                send_from_set(1, digits);
                send_from_set($urandom_range(0, 3), digits);
                send_from_set(1, "aZ_?.-+");
                send_from_set($urandom_range(0, 3), symbols);
            end
            if ($urandom_range(0, 4) != 0)
                send_separator();
        end
        else if (pick < 88)
        begin
            send_item(ACTION_BYTE, 8'($urandom_range(0, 255)));
        end
        else if (pick < 92)
        begin
            send_item(ACTION_END, 8'($urandom_range(0, 255)));
        end
        else
        begin
            send_text(extremes[$urandom_range(0, 7)]);
            send_separator();
        end
    endtask

    initial
    begin
        int next_drain;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACTION_BYTE;
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        items_sent   = 0;
        quiet_cycles = 0;
        next_drain   = 250;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: parens, an integer, a word ended by a paren, comment, odd bytes, end cases.
        send_text("(-42 1a)\t;x\n");
        send_item(ACTION_BYTE, CH_CR);
        send_item(ACTION_BYTE, 8'h00);
        send_item(ACTION_BYTE, 8'hFF);
        send_item(ACTION_BYTE, 8'h80);
        send_item(ACTION_BYTE, CH_MINUS);
        send_item(ACTION_END, 8'hFF);
        send_text("z9");
        send_item(ACTION_END, 8'h00);
        send_item(ACTION_END, 8'h55);
        drain_results();

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET * 4 / 5)
                idle_on = 1'b0;
            if (items_sent >= next_drain)
            begin
                drain_results();
                next_drain += 250;
            end
            send_random_token();
        end
        send_item(ACTION_END, 8'($urandom_range(0, 255)));

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS sexpr_token_lexer_top");
        else
            $display("FAIL sexpr_token_lexer_top");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sxl_pkg.sv
hdl/sxl_outq.sv
hdl/sxl_scan.sv
hdl/sexpr_token_lexer_top.sv
hdl/sxl_chk.sv
bench/sexpr_token_lexer_checker.sv
bench/tb_sexpr_token_lexer_top.sv
